[hw/rtl/mmn_pkg.sv]
package mmn_pkg;

    localparam int ENTRY_CAPACITY = 64;
    localparam int MAX_REGIONS    = 32;
    localparam int PAGE_SIZE      = 4096;
    localparam int CAND_DEPTH     = ENTRY_CAPACITY * 3;
    localparam int CAND_AW        = $clog2(CAND_DEPTH);
    localparam int CAND_CW        = $clog2(CAND_DEPTH + 1);
    localparam int OUT_AW         = $clog2(MAX_REGIONS);
    localparam int OUT_CW         = $clog2(MAX_REGIONS + 1);
    localparam int SEEN_W         = $clog2(ENTRY_CAPACITY + 1);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W         = 53;

    localparam logic [5:0] AB_MIN   = 6'd32;
    localparam logic [5:0] AB_MAX   = 6'd52;
    localparam logic [5:0] AB_RESET = 6'd52;

    localparam logic [31:0] SIZE_SHORT = 32'd20;
    localparam logic [31:0] SIZE_LONG  = 32'd24;

    localparam logic [2:0] K_HOLE       = 3'd0;
    localparam logic [2:0] K_USABLE     = 3'd1;
    localparam logic [2:0] K_RESERVED   = 3'd2;
    localparam logic [2:0] K_RECLAIM    = 3'd3;
    localparam logic [2:0] K_NVS        = 3'd4;
    localparam logic [2:0] K_BAD        = 3'd5;
    localparam logic [2:0] K_PERSISTENT = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_WIDTH    = 3'd1;
    localparam logic [2:0] ST_SIZE     = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_CAPACITY = 3'd5;
    localparam logic [2:0] ST_ENTRIES  = 3'd6;

    typedef struct packed {
        logic [63:0] entry_base;
        logic [63:0] entry_length;
        logic [31:0] entry_type;
        logic [31:0] entry_size;
        logic [31:0] entry_attributes;
        logic [31:0] entry_reserved;
        logic        last_entry;
    } t_entry;

    typedef struct packed {
        logic [ADDR_W-1:0] region_base;
        logic [ADDR_W-1:0] region_end;
        logic [2:0]        region_kind;
        logic [2:0]        status;
        logic              last_result;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0] c_base;
        logic [ADDR_W-1:0] c_end;
        logic [2:0]        c_kind;
    } t_cand;

    typedef struct packed {
        t_cand [2:0] cands;
        logic [2:0]  cv;
        logic        last;
        logic [2:0]  status;
        logic [5:0]  abits;
    } t_job;

    typedef enum logic [3:0] {
        B_IDLE, B_WRITE, B_CHECK, B_MIN, B_SCAN, B_FIN, B_EMIT, B_ERR, B_DONE
    } t_bstate;

    function automatic logic [2:0] rank_of(logic [2:0] k);
        logic [2:0] r;
        case (k)
            K_USABLE:     r = 3'd1;
            K_RECLAIM:    r = 3'd2;
            K_PERSISTENT: r = 3'd3;
            K_NVS:        r = 3'd4;
            K_BAD:        r = 3'd6;
            default:      r = 3'd5;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/mmn_queue.sv]
module mmn_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  mmn_pkg::t_job                 i_data,
    input  logic                          i_pop,
    output mmn_pkg::t_job                 o_data,
    output logic                          o_empty,
    output logic [mmn_pkg::QUEUE_CW-1:0]  o_count
);

    mmn_pkg::t_job r_slots [mmn_pkg::QUEUE_DEPTH];
    logic [mmn_pkg::QUEUE_AW-1:0] r_wp;
    logic [mmn_pkg::QUEUE_AW-1:0] r_rp;
    logic [mmn_pkg::QUEUE_CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wp] <= i_data;
        end
    end

    assign o_data  = r_slots[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

[hw/rtl/mmn_front.sv]
module mmn_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  mmn_pkg::t_entry              i_entry,
    input  logic [5:0]                   i_abits,
    input  logic [mmn_pkg::QUEUE_CW-1:0] i_q_count,
    input  logic                         i_done,
    output logic                         o_busy,
    output logic                         o_push,
    output mmn_pkg::t_job                o_job
);

    localparam int QUEUE_SUM_W = mmn_pkg::QUEUE_CW + 1;

    logic                              r_stg_v;
    mmn_pkg::t_entry                   r_ent;
    logic [5:0]                        r_ab;
    logic                              r_last_pend;
    logic [mmn_pkg::SEEN_W-1:0]        r_seen;
    logic [2:0]                        r_err;
    logic [mmn_pkg::SEEN_W-1:0]        n_seen;
    logic [2:0]                        n_err;

    logic        accept;
    logic        over;
    logic        width_bad;
    logic        size_ok;
    logic        enabled;
    logic        rng_bad;
    logic        do_store;
    logic        known;
    logic        forced;
    logic [2:0]  kind;
    logic [2:0]  te;
    logic [63:0] limit;
    logic [63:0] pm;
    logic [63:0] endv;
    logic [63:0] low;
    logic [63:0] high;
    logic [63:0] startv;
    logic [63:0] fin;
    logic [QUEUE_SUM_W-1:0] fill;

    assign fill   = QUEUE_SUM_W'(i_q_count) + QUEUE_SUM_W'(r_stg_v);
    assign o_busy = r_last_pend || (fill >= QUEUE_SUM_W'(mmn_pkg::QUEUE_DEPTH - 1));
    assign accept = i_start && !o_busy;

    always_comb begin
        pm        = 64'(mmn_pkg::PAGE_SIZE - 1);
        limit     = 64'd1 << r_ab;
        over      = (r_seen >= mmn_pkg::SEEN_W'(mmn_pkg::ENTRY_CAPACITY));
        width_bad = (r_ab < mmn_pkg::AB_MIN) || (r_ab > mmn_pkg::AB_MAX);
        size_ok   = ((r_ent.entry_size == mmn_pkg::SIZE_SHORT) ||
                     (r_ent.entry_size == mmn_pkg::SIZE_LONG)) &&
                    (r_ent.entry_reserved == 32'd0);
        enabled   = !((r_ent.entry_size == mmn_pkg::SIZE_LONG) &&
                      !r_ent.entry_attributes[0]);
        rng_bad   = (r_ent.entry_base >= limit) ||
                    (r_ent.entry_length > (limit - r_ent.entry_base));
        if (!size_ok) begin
            te = mmn_pkg::ST_SIZE;
        end else if (!enabled || r_ent.entry_length == 64'd0) begin
            te = mmn_pkg::ST_OK;
        end else if (rng_bad) begin
            te = mmn_pkg::ST_RANGE;
        end else begin
            te = mmn_pkg::ST_OK;
        end
        do_store = size_ok && enabled && (r_ent.entry_length != 64'd0) && !rng_bad &&
                   !width_bad && !over && (r_err == mmn_pkg::ST_OK);

        endv   = r_ent.entry_base + r_ent.entry_length;
        low    = r_ent.entry_base & ~pm;
        high   = (endv + pm) & ~pm;
        startv = (r_ent.entry_base + pm) & ~pm;
        fin    = endv & ~pm;

        known  = (r_ent.entry_type == 32'(mmn_pkg::K_USABLE)) ||
                 (r_ent.entry_type == 32'(mmn_pkg::K_RECLAIM)) ||
                 (r_ent.entry_type == 32'(mmn_pkg::K_NVS)) ||
                 (r_ent.entry_type == 32'(mmn_pkg::K_BAD)) ||
                 (r_ent.entry_type == 32'(mmn_pkg::K_PERSISTENT));
        forced = (r_ent.entry_size == mmn_pkg::SIZE_LONG) &&
                 (r_ent.entry_attributes[31:1] != 31'd0);
        kind   = (!known || forced) ? mmn_pkg::K_RESERVED : r_ent.entry_type[2:0];

        o_job        = '0;
        o_job.last   = r_ent.last_entry;
        o_job.abits  = r_ab;
        if (kind != mmn_pkg::K_USABLE) begin
            o_job.cands[1] = '{low[52:0], high[52:0], kind};
            o_job.cv       = 3'b010;
        end else if (startv >= fin) begin
            o_job.cands[1] = '{low[52:0], high[52:0], mmn_pkg::K_RESERVED};
            o_job.cv       = 3'b010;
        end else begin
            // usable core with reserved slivers at each ragged edge
            o_job.cands[0] = '{low[52:0], startv[52:0], mmn_pkg::K_RESERVED};
            o_job.cands[1] = '{startv[52:0], fin[52:0], mmn_pkg::K_USABLE};
            o_job.cands[2] = '{fin[52:0], high[52:0], mmn_pkg::K_RESERVED};
            o_job.cv       = {fin < high, 1'b1, low < startv};
        end
        if (!do_store) begin
            o_job.cv = 3'b000;
        end

        n_seen = over ? r_seen : r_seen + 1'b1;
        if (width_bad) begin
            n_err = mmn_pkg::ST_WIDTH;
        end else if (over) begin
            n_err = (r_err != mmn_pkg::ST_WIDTH) ? mmn_pkg::ST_ENTRIES : r_err;
        end else if (r_err == mmn_pkg::ST_OK) begin
            n_err = te;
        end else begin
            n_err = r_err;
        end
        o_job.status = n_err;
    end

    assign o_push = r_stg_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_v     <= 1'b0;
            r_last_pend <= 1'b0;
            r_seen      <= '0;
            r_err       <= mmn_pkg::ST_OK;
        end else begin
            r_stg_v <= accept;
            if (accept && i_entry.last_entry) begin
                r_last_pend <= 1'b1;
            end else if (i_done) begin
                r_last_pend <= 1'b0;
            end
            if (r_stg_v) begin
                if (r_ent.last_entry) begin
                    r_seen <= '0;
                    r_err  <= mmn_pkg::ST_OK;
                end else begin
                    r_seen <= n_seen;
                    r_err  <= n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent <= i_entry;
            r_ab  <= i_abits;
        end
    end

endmodule

[hw/rtl/mmn_back.sv]
module mmn_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  mmn_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_done,
    output logic              o_result_valid,
    output mmn_pkg::t_result  o_result
);

    localparam int AW = mmn_pkg::ADDR_W;

    mmn_pkg::t_bstate r_state;
    mmn_pkg::t_bstate n_state;

    mmn_pkg::t_cand cand_mem [mmn_pkg::CAND_DEPTH];
    mmn_pkg::t_cand out_mem  [mmn_pkg::MAX_REGIONS];
    mmn_pkg::t_cand r_crd;
    mmn_pkg::t_cand r_ord;

    mmn_pkg::t_job               r_job,    n_job;
    logic [1:0]                  r_slot,   n_slot;
    logic [mmn_pkg::CAND_CW-1:0] r_used,   n_used;
    logic [mmn_pkg::CAND_CW-1:0] r_ridx,   n_ridx;
    logic                        r_rv,     n_rv;
    logic                        r_rlast,  n_rlast;
    logic [AW-1:0]               r_cursor, n_cursor;
    logic [AW-1:0]               r_next,   n_next;
    logic [2:0]                  r_kind,   n_kind;
    logic [2:0]                  r_rank,   n_rank;
    logic [AW-1:0]               r_limit,  n_limit;
    logic [mmn_pkg::OUT_CW-1:0]  r_ocnt,   n_ocnt;
    logic [AW-1:0]               r_lbase,  n_lbase;
    logic [AW-1:0]               r_lend,   n_lend;
    logic [2:0]                  r_lkind,  n_lkind;
    logic [mmn_pkg::OUT_CW-1:0]  r_eidx,   n_eidx;
    logic [2:0]                  r_est,    n_est;
    logic                        r_ov,     n_ov;
    logic                        r_olast,  n_olast;
    logic                        r_oerr,   n_oerr;

    logic                        c_we;
    logic [mmn_pkg::CAND_AW-1:0] c_waddr;
    mmn_pkg::t_cand              c_wdata;
    logic                        c_re;
    logic                        o_we;
    logic [mmn_pkg::OUT_AW-1:0]  o_waddr;
    mmn_pkg::t_cand              o_wdata;
    logic                        o_re;

    logic          scanning;
    logic          pass_end;
    logic [AW-1:0] u_min;
    logic [AW-1:0] u_next;
    logic [2:0]    u_kind;
    logic [2:0]    u_rank;
    logic          merge;
    logic          overflow;
    logic          emit_last;

    assign scanning = (r_state == mmn_pkg::B_MIN) || (r_state == mmn_pkg::B_SCAN);
    assign c_re     = scanning && (r_ridx < r_used);
    assign pass_end = r_rv && r_rlast;

    // one candidate folded into the running boundary search per cycle
    always_comb begin
        u_min  = (r_crd.c_base < r_cursor) ? r_crd.c_base : r_cursor;
        u_next = r_next;
        if (r_crd.c_base > r_cursor && r_crd.c_base < u_next) begin
            u_next = r_crd.c_base;
        end
        if (r_crd.c_end > r_cursor && r_crd.c_end < u_next) begin
            u_next = r_crd.c_end;
        end
        u_kind = r_kind;
        u_rank = r_rank;
        if (r_crd.c_base <= r_cursor && r_cursor < r_crd.c_end &&
            mmn_pkg::rank_of(r_crd.c_kind) > r_rank) begin
            u_kind = r_crd.c_kind;
            u_rank = mmn_pkg::rank_of(r_crd.c_kind);
        end
        merge    = (r_ocnt != '0) && (r_lend == r_cursor) && (r_lkind == u_kind);
        overflow = r_ocnt >= mmn_pkg::OUT_CW'(mmn_pkg::MAX_REGIONS);
        emit_last = (r_eidx + 1'b1 == r_ocnt);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mmn_pkg::B_IDLE: begin
                if (!i_empty) begin
                    n_state = mmn_pkg::B_WRITE;
                end
            end
            mmn_pkg::B_WRITE: begin
                if (r_slot == 2'd2) begin
                    n_state = r_job.last ? mmn_pkg::B_CHECK : mmn_pkg::B_IDLE;
                end
            end
            mmn_pkg::B_CHECK: begin
                if (r_job.status != mmn_pkg::ST_OK || r_used == '0) begin
                    n_state = mmn_pkg::B_ERR;
                end else begin
                    n_state = mmn_pkg::B_MIN;
                end
            end
            mmn_pkg::B_MIN: begin
                if (pass_end) begin
                    n_state = (u_min < r_limit) ? mmn_pkg::B_SCAN : mmn_pkg::B_FIN;
                end
            end
            mmn_pkg::B_SCAN: begin
                if (pass_end) begin
                    if (u_kind != mmn_pkg::K_HOLE && !merge && overflow) begin
                        n_state = mmn_pkg::B_ERR;
                    end else if (u_next >= r_limit) begin
                        n_state = mmn_pkg::B_FIN;
                    end
                end
            end
            mmn_pkg::B_FIN: begin
                n_state = (r_ocnt == '0) ? mmn_pkg::B_ERR : mmn_pkg::B_EMIT;
            end
            mmn_pkg::B_EMIT: begin
                if (emit_last) begin
                    n_state = mmn_pkg::B_DONE;
                end
            end
            mmn_pkg::B_ERR: begin
                n_state = mmn_pkg::B_DONE;
            end
            mmn_pkg::B_DONE: begin
                n_state = mmn_pkg::B_IDLE;
            end
            default: begin
                n_state = mmn_pkg::B_IDLE;
            end
        endcase
    end

    always_comb begin
        n_job    = r_job;
        n_slot   = r_slot;
        n_used   = r_used;
        n_ridx   = r_ridx;
        n_rv     = c_re;
        n_rlast  = c_re && (r_ridx + 1'b1 == r_used);
        n_cursor = r_cursor;
        n_next   = r_next;
        n_kind   = r_kind;
        n_rank   = r_rank;
        n_limit  = r_limit;
        n_ocnt   = r_ocnt;
        n_lbase  = r_lbase;
        n_lend   = r_lend;
        n_lkind  = r_lkind;
        n_eidx   = r_eidx;
        n_est    = r_est;
        n_ov     = 1'b0;
        n_olast  = 1'b0;
        n_oerr   = 1'b0;
        o_pop    = 1'b0;
        o_done   = 1'b0;
        c_we     = 1'b0;
        c_waddr  = r_used[mmn_pkg::CAND_AW-1:0];
        c_wdata  = r_job.cands[r_slot];
        o_we     = 1'b0;
        o_waddr  = r_ocnt[mmn_pkg::OUT_AW-1:0];
        o_wdata  = '{r_cursor, u_next, u_kind};
        o_re     = 1'b0;
        if (c_re) begin
            n_ridx = r_ridx + 1'b1;
        end
        case (r_state)
            mmn_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_job  = i_job;
                    n_slot = 2'd0;
                end
            end
            mmn_pkg::B_WRITE: begin
                if (r_job.cv[r_slot]) begin
                    c_we   = 1'b1;
                    n_used = r_used + 1'b1;
                end
                n_slot = r_slot + 1'b1;
            end
            mmn_pkg::B_CHECK: begin
                n_limit  = AW'(1) << r_job.abits;
                n_cursor = AW'(1) << r_job.abits;
                n_ridx   = '0;
                n_est    = (r_job.status != mmn_pkg::ST_OK) ? r_job.status
                                                            : mmn_pkg::ST_EMPTY;
            end
            mmn_pkg::B_MIN: begin
                if (r_rv) begin
                    n_cursor = u_min;
                end
                if (pass_end) begin
                    n_next = r_limit;
                    n_kind = mmn_pkg::K_HOLE;
                    n_rank = 3'd0;
                    n_ridx = '0;
                end
            end
            mmn_pkg::B_SCAN: begin
                if (r_rv) begin
                    n_next = u_next;
                    n_kind = u_kind;
                    n_rank = u_rank;
                end
                if (pass_end) begin
                    if (u_kind != mmn_pkg::K_HOLE) begin
                        if (merge) begin
                            o_we    = 1'b1;
                            o_waddr = mmn_pkg::OUT_AW'(r_ocnt - 1'b1);
                            o_wdata = '{r_lbase, u_next, u_kind};
                            n_lend  = u_next;
                        end else if (overflow) begin
                            n_est = mmn_pkg::ST_CAPACITY;
                        end else begin
                            o_we    = 1'b1;
                            n_lbase = r_cursor;
                            n_lend  = u_next;
                            n_lkind = u_kind;
                            n_ocnt  = r_ocnt + 1'b1;
                        end
                    end
                    n_cursor = u_next;
                    n_next   = r_limit;
                    n_kind   = mmn_pkg::K_HOLE;
                    n_rank   = 3'd0;
                    n_ridx   = '0;
                end
            end
            mmn_pkg::B_FIN: begin
                n_eidx = '0;
                n_est  = mmn_pkg::ST_EMPTY;
            end
            mmn_pkg::B_EMIT: begin
                o_re    = 1'b1;
                n_ov    = 1'b1;
                n_olast = emit_last;
                n_eidx  = r_eidx + 1'b1;
            end
            mmn_pkg::B_ERR: begin
                n_ov    = 1'b1;
                n_olast = 1'b1;
                n_oerr  = 1'b1;
            end
            mmn_pkg::B_DONE: begin
                n_used = '0;
                n_ocnt = '0;
                o_done = 1'b1;
            end
            default: begin
                n_used = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmn_pkg::B_IDLE;
            r_used  <= '0;
            r_ocnt  <= '0;
            r_rv    <= 1'b0;
            r_rlast <= 1'b0;
            r_ridx  <= '0;
            r_ov    <= 1'b0;
            r_olast <= 1'b0;
            r_oerr  <= 1'b0;
            r_slot  <= '0;
            r_eidx  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_ocnt  <= n_ocnt;
            r_rv    <= n_rv;
            r_rlast <= n_rlast;
            r_ridx  <= n_ridx;
            r_ov    <= n_ov;
            r_olast <= n_olast;
            r_oerr  <= n_oerr;
            r_slot  <= n_slot;
            r_eidx  <= n_eidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_cursor <= n_cursor;
        r_next   <= n_next;
        r_kind   <= n_kind;
        r_rank   <= n_rank;
        r_limit  <= n_limit;
        r_lbase  <= n_lbase;
        r_lend   <= n_lend;
        r_lkind  <= n_lkind;
        r_est    <= n_est;
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            cand_mem[c_waddr] <= c_wdata;
        end
        if (c_re) begin
            r_crd <= cand_mem[r_ridx[mmn_pkg::CAND_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_we) begin
            out_mem[o_waddr] <= o_wdata;
        end
        if (o_re) begin
            r_ord <= out_mem[r_eidx[mmn_pkg::OUT_AW-1:0]];
        end
    end

    assign o_result_valid = r_ov;

    always_comb begin
        if (r_oerr) begin
            o_result             = '0;
            o_result.status      = r_est;
            o_result.last_result = 1'b1;
        end else begin
            o_result.region_base = r_ord.c_base;
            o_result.region_end  = r_ord.c_end;
            o_result.region_kind = r_ord.c_kind;
            o_result.status      = mmn_pkg::ST_OK;
            o_result.last_result = r_olast;
        end
    end

endmodule

[hw/rtl/memory_map_normalizer_top.sv]
// memory map normaliser: firmware map entries in, sorted disjoint regions out
// input: an entry beat is taken when start is high and busy is low
// entries are checked and cut into page-aligned candidates by the front end,
// which passes them through a four-slot queue to the back end for storage
// the front end takes entries back to back until three are waiting; the back
// end pops each entry and then stores its candidate slots one at a time,
// so busy paces a long map to the speed of the back end
// the entry flagged last raises busy until every result of the map is out
// back end then runs the boundary sweep: one pass over all n stored
// candidates per boundary, one candidate read per cycle from the
// candidate memory
// results then stream out one per cycle on o_result with o_result_valid
// high for exactly one cycle each; the last carries last_result
// an error gives a single status beat in place of the regions
// the receiver cannot stall; results are never held
// config: i_cfg_we writes address_bits; write only while idle
// reset (synchronous, active low) clears all map state, address_bits to 52
module memory_map_normalizer_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  mmn_pkg::t_entry   i_entry,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic [5:0]        i_cfg_wdata,
    output logic              o_result_valid,
    output mmn_pkg::t_result  o_result
);

    logic [5:0]                   r_abits;
    logic                         push;
    mmn_pkg::t_job                push_job;
    logic                         pop;
    mmn_pkg::t_job                head_job;
    logic                         q_empty;
    logic [mmn_pkg::QUEUE_CW-1:0] q_count;
    logic                         done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abits <= mmn_pkg::AB_RESET;
        end else if (i_cfg_we) begin
            r_abits <= i_cfg_wdata;
        end
    end

    mmn_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_entry   (i_entry),
        .i_abits   (r_abits),
        .i_q_count (q_count),
        .i_done    (done),
        .o_busy    (busy),
        .o_push    (push),
        .o_job     (push_job)
    );

    mmn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    mmn_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_job          (head_job),
        .o_pop          (pop),
        .o_done         (done),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
